FILE: hw/rtl/msq_pkg.sv
package msq_pkg;

   // stream payload widths
   localparam int SAMPLE_W = 16;
   localparam int COORD_W  = 22;
   localparam int FRAC_W   = 12;
   localparam int RSP_W    = 88;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTOUR_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLUMNS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS     = 2'd2;

   // row geometry
   localparam int ROW_W    = 10;
   localparam int ROW_MAX  = 1024;
   localparam int GRID_REG_W = 11;

   // q16 fractions and the shared divider
   localparam int Q16_FRAC = 16;
   localparam int Q16_W    = 17;
   localparam int DIV_W    = 34;
   localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] numer;
      logic [DIV_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [Q16_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/msq_ram.sv
module msq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/msq_divider.sv
module msq_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  msq_pkg::div_req_type req,
   output msq_pkg::div_rsp_type rsp
);

   import msq_pkg::*;

   localparam int CNT_W = $clog2(Q16_FRAC);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   den_ff;
   logic [Q16_W-1:0]   quo_ff;
   logic               done_ff;

   logic [DIV_W:0]     rem_sh;
   logic               fits;

   // one restoring step per cycle
   assign rem_sh = {rem_ff, 1'b0};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req.start) begin
                  // zero and saturated quotients need no iteration
                  if (req.numer == '0) begin
                     quo_ff  <= '0;
                     done_ff <= 1'b1;
                  end else if (req.numer >= req.denom) begin
                     quo_ff  <= ONE_Q16;
                     done_ff <= 1'b1;
                  end else begin
                     rem_ff   <= req.numer;
                     den_ff   <= req.denom;
                     quo_ff   <= '0;
                     count_ff <= CNT_W'(Q16_FRAC - 1);
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (fits) begin
                  rem_ff <= DIV_W'(rem_sh - {1'b0, den_ff});
               end else begin
                  rem_ff <= rem_sh[DIV_W-1:0];
               end
               quo_ff <= {quo_ff[Q16_W-2:0], fits};
               if (count_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  count_ff <= count_ff - 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/marching_squares_segmenter_core.sv
// marching squares isoline segmenter
// req channel: one signed grid sample per transaction, raster order, row by row.
// rsp channel: zero, one or two segments per sample; tdata carries the start and
// end points in cell units (unsigned 10.12), tlast marks the final segment of a cell.
// csr port: contour level, grid columns and grid rows, written only while the block
// idles: a rule for the user that the block does not enforce. a sample in the first
// row or first column gives no segment. any other sample closes a cell: the crossings
// on all its edges go through the shared restoring divider; a saddle cell adds one more
// division and seven multiplier steps, or only two multiplier steps and no division
// when the denominator is not positive. the divider is the unit that sets the rate.
// one sample is worked on at a time; req_tready is low from acceptance until the
// last segment of that sample has been taken.
// when the receiver stalls, rsp_tvalid and rsp_tdata hold and nothing new is taken.
// reset clears the counters and the neighbour registers, sets level 0 and a 2x2 grid;
// the row store is not cleared, the first row of each frame fills it.
module marching_squares_segmenter_core #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [msq_pkg::SAMPLE_W-1:0]      req_tdata,   // sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [msq_pkg::RSP_W-1:0]         rsp_tdata,   // start_x, start_y, end_x, end_y
   output logic                              rsp_tlast,
   input  logic                              csr_write,
   input  logic [msq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import msq_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int CW = AW + 1;
   localparam logic signed [42:0] TWO_POW_32 = 43'sd4294967296;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_EDGE_GO,
      ST_EDGE_WAIT,
      ST_CLASSIFY,
      ST_DXDY,
      ST_FBDY,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DXY,
      ST_XCLAMP,
      ST_PMUL,
      ST_QMUL,
      ST_DIFF,
      ST_HIMUL,
      ST_LOMUL,
      ST_FINAL,
      ST_OUT0,
      ST_OUT1
   } state_type;

   typedef enum logic [2:0] {
      PAIR_BR,
      PAIR_LB,
      PAIR_LR,
      PAIR_TR,
      PAIR_BT,
      PAIR_LT
   } pair_type;

   // configuration
   logic signed [SAMPLE_W-1:0] level_ff;
   logic [GRID_REG_W-1:0]      grid_columns_ff;
   logic [GRID_REG_W-1:0]      grid_rows_ff;

   // control
   state_type        state_ff;
   logic [AW-1:0]    column_count_ff;
   logic [ROW_W-1:0] row_count_ff;
   logic [AW-1:0]    cur_col_ff;
   logic [ROW_W-1:0] cur_row_ff;
   logic [1:0]       edge_idx_ff;
   logic             two_segs_ff;
   pair_type         kind0_ff;
   pair_type         kind1_ff;

   // neighbours and corners
   logic signed [SAMPLE_W-1:0] left_ff;
   logic signed [SAMPLE_W-1:0] upper_left_ff;
   logic signed [SAMPLE_W-1:0] a00_ff, a01_ff, a10_ff, a11_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   // fractions and saddle datapath
   logic [Q16_W-1:0]   frac_b_ff, frac_t_ff, frac_l_ff, frac_r_ff;
   logic [Q16_W-1:0]   y_ff, x_ff;
   logic signed [42:0] prod_ff;
   logic signed [42:0] den_ff;
   logic signed [42:0] hi_ff;
   logic signed [39:0] p_ff;
   logic [39:0]        m_ff;
   logic               neg_ff;

   // ram and divider links
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [AW-1:0]       ram_raddr;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // effective geometry
   logic [CW-1:0]      cols_eff;
   logic [ROW_W:0]     rows_eff;
   logic [31:0]        gc32, gr32;
   logic [AW-1:0]      col_pre;
   logic [ROW_W-1:0]   row_pre;
   logic [ROW_W:0]     row_bump;
   logic [CW-1:0]      col_next;
   logic [ROW_W:0]     row_next;

   assign gc32 = 32'(grid_columns_ff);
   assign gr32 = 32'(grid_rows_ff);

   always_comb begin
      if (gc32 < 32'd2) begin
         cols_eff = CW'(2);
      end else if (gc32 > 32'(MAX_COLUMNS)) begin
         cols_eff = CW'(MAX_COLUMNS);
      end else begin
         cols_eff = CW'(gc32);
      end
      if (gr32 < 32'd2) begin
         rows_eff = (ROW_W+1)'(2);
      end else if (gr32 > 32'(ROW_MAX)) begin
         rows_eff = (ROW_W+1)'(ROW_MAX);
      end else begin
         rows_eff = (ROW_W+1)'(gr32);
      end
   end

   // wrap the counters before the sample is used
   always_comb begin
      col_pre  = column_count_ff;
      row_bump = {1'b0, row_count_ff};
      if ({1'b0, column_count_ff} >= cols_eff) begin
         col_pre  = '0;
         row_bump = {1'b0, row_count_ff} + 1'b1;
      end
      if (row_bump >= rows_eff) begin
         row_pre = '0;
      end else begin
         row_pre = row_bump[ROW_W-1:0];
      end
   end

   // counters after the sample
   assign col_next = {1'b0, cur_col_ff} + 1'b1;
   assign row_next = {1'b0, cur_row_ff} + 1'b1;

   assign ram_raddr = col_pre;

   msq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_COLUMNS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (cur_col_ff),
      .wr_data (sample_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // edge operands for the divider
   logic signed [SAMPLE_W-1:0] ea, eb;
   logic signed [16:0]         en, ed, en_abs, ed_abs;
   logic [DIV_W-1:0]           edge_num, edge_den;

   always_comb begin
      case (edge_idx_ff)
         2'd0:    begin ea = a00_ff; eb = a01_ff; end
         2'd1:    begin ea = a10_ff; eb = a11_ff; end
         2'd2:    begin ea = a00_ff; eb = a10_ff; end
         default: begin ea = a01_ff; eb = a11_ff; end
      endcase
      en = 17'(level_ff) - 17'(ea);
      ed = 17'(eb) - 17'(ea);
      if (ed < 0) begin
         en_abs = -en;
         ed_abs = -ed;
      end else begin
         en_abs = en;
         ed_abs = ed;
      end
      edge_den = {17'b0, ed_abs};
      if (ed_abs == 0 || en_abs <= 0) begin
         edge_num = '0;
      end else begin
         edge_num = {17'b0, en_abs};
      end
   end

   // saddle quantities
   logic signed [17:0] dx, dy, dx_abs;
   logic signed [42:0] num_v;
   logic [16:0]        t_v;
   logic signed [18:0] xs;
   logic signed [39:0] q_v, diff_v, r_v, f_v, lvl_v;
   logic signed [16:0] d_top, d_bot;

   assign dx     = $signed({1'b0, frac_t_ff}) - $signed({1'b0, frac_b_ff});
   assign dy     = $signed({1'b0, frac_r_ff}) - $signed({1'b0, frac_l_ff});
   assign dx_abs = (dx < 0) ? -dx : dx;
   assign num_v  = prod_ff + 43'($signed({1'b0, frac_l_ff, 16'b0}));
   assign t_v    = prod_ff[32:16];
   assign xs     = (dx < 0) ? $signed({2'b0, frac_b_ff}) - $signed({2'b0, t_v})
                            : $signed({2'b0, frac_b_ff}) + $signed({2'b0, t_v});
   assign d_top  = 17'(a01_ff) - 17'(a00_ff);
   assign d_bot  = 17'(a11_ff) - 17'(a10_ff);
   assign q_v    = (40'(a10_ff) <<< 16) + 40'(prod_ff);
   assign diff_v = q_v - p_ff;
   assign r_v    = 40'(hi_ff) + 40'(prod_ff >>> 16);
   assign f_v    = neg_ff ? p_ff - r_v : p_ff + r_v;
   assign lvl_v  = 40'(level_ff) <<< 16;

   // the one multiplier, operands chosen by state, product registered
   logic signed [24:0] mul_a;
   logic signed [17:0] mul_b;

   always_comb begin
      mul_a = 25'(dx);
      mul_b = dy;
      case (state_ff)
         ST_FBDY:  begin mul_a = $signed({8'b0, frac_b_ff});  mul_b = dy; end
         ST_DXY:   begin mul_a = 25'(dx_abs); mul_b = $signed({1'b0, y_ff}); end
         ST_PMUL:  begin mul_a = 25'(d_top);  mul_b = $signed({1'b0, x_ff}); end
         ST_QMUL:  begin mul_a = 25'(d_bot);  mul_b = $signed({1'b0, x_ff}); end
         ST_HIMUL: begin
            mul_a = $signed({1'b0, m_ff[39:16]});
            mul_b = $signed({1'b0, y_ff});
         end
         ST_LOMUL: begin
            mul_a = $signed({9'b0, m_ff[15:0]});
            mul_b = $signed({1'b0, y_ff});
         end
         default:  begin mul_a = 25'(dx); mul_b = dy; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 43'(mul_a * mul_b);
   end

   // divider requests
   always_comb begin
      div_req.start = 1'b0;
      div_req.numer = edge_num;
      div_req.denom = edge_den;
      if (state_ff == ST_EDGE_GO) begin
         div_req.start = 1'b1;
      end else if (state_ff == ST_DIV_GO) begin
         div_req.start = den_ff > 0;
         div_req.numer = (num_v > 0) ? num_v[DIV_W-1:0] : '0;
         div_req.denom = den_ff[DIV_W-1:0];
      end
   end

   msq_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // case code of the cell
   logic [3:0] code;
   assign code = {a10_ff >= level_ff, a11_ff >= level_ff,
                  a00_ff >= level_ff, a01_ff >= level_ff};

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         level_ff        <= '0;
         grid_columns_ff <= GRID_REG_W'(2);
         grid_rows_ff    <= GRID_REG_W'(2);
         column_count_ff <= '0;
         row_count_ff    <= '0;
         left_ff         <= '0;
         upper_left_ff   <= '0;
         edge_idx_ff     <= '0;
         two_segs_ff     <= 1'b0;
      end else begin
         // register writes
         if (csr_write) begin
            unique case (csr_index)
               CSR_CONTOUR_LEVEL: level_ff <= $signed(csr_wdata);
               CSR_GRID_COLUMNS:  grid_columns_ff <= csr_wdata[GRID_REG_W-1:0];
               CSR_GRID_ROWS:     grid_rows_ff <= csr_wdata[GRID_REG_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  sample_ff  <= $signed(req_tdata);
                  cur_col_ff <= col_pre;
                  cur_row_ff <= row_pre;
                  state_ff   <= ST_READ;
               end
            end
            ST_READ: begin
               a00_ff        <= upper_left_ff;
               a01_ff        <= $signed(ram_rdata);
               a10_ff        <= left_ff;
               a11_ff        <= sample_ff;
               upper_left_ff <= $signed(ram_rdata);
               left_ff       <= sample_ff;
               if (col_next >= cols_eff) begin
                  column_count_ff <= '0;
                  row_count_ff    <= (row_next >= rows_eff) ? '0 : row_next[ROW_W-1:0];
               end else begin
                  column_count_ff <= col_next[AW-1:0];
                  row_count_ff    <= cur_row_ff;
               end
               edge_idx_ff <= '0;
               if (cur_col_ff != '0 && cur_row_ff != '0) begin
                  state_ff <= ST_EDGE_GO;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EDGE_GO: state_ff <= ST_EDGE_WAIT;
            ST_EDGE_WAIT: begin
               if (div_rsp.done) begin
                  case (edge_idx_ff)
                     2'd0:    frac_b_ff <= div_rsp.quotient;
                     2'd1:    frac_t_ff <= div_rsp.quotient;
                     2'd2:    frac_l_ff <= div_rsp.quotient;
                     default: frac_r_ff <= div_rsp.quotient;
                  endcase
                  edge_idx_ff <= edge_idx_ff + 1'b1;
                  state_ff    <= (edge_idx_ff == 2'd3) ? ST_CLASSIFY : ST_EDGE_GO;
               end
            end
            ST_CLASSIFY: begin
               two_segs_ff <= 1'b0;
               state_ff    <= ST_OUT0;
               case (code)
                  4'd1, 4'd14: kind0_ff <= PAIR_BR;
                  4'd2, 4'd13: kind0_ff <= PAIR_LB;
                  4'd3, 4'd12: kind0_ff <= PAIR_LR;
                  4'd4, 4'd11: kind0_ff <= PAIR_TR;
                  4'd5, 4'd10: kind0_ff <= PAIR_BT;
                  4'd7, 4'd8:  kind0_ff <= PAIR_LT;
                  4'd6, 4'd9:  state_ff <= ST_DXDY;
                  default:     state_ff <= ST_IDLE;
               endcase
            end
            ST_DXDY: state_ff <= ST_FBDY;
            ST_FBDY: begin
               den_ff   <= TWO_POW_32 - prod_ff;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               if (den_ff > 0) begin
                  state_ff <= ST_DIV_WAIT;
               end else begin
                  // denominator not positive: left-bottom and top-right pairing
                  kind0_ff    <= PAIR_LB;
                  kind1_ff    <= PAIR_TR;
                  two_segs_ff <= 1'b1;
                  state_ff    <= ST_OUT0;
               end
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  y_ff     <= div_rsp.quotient;
                  state_ff <= ST_DXY;
               end
            end
            ST_DXY: state_ff <= ST_XCLAMP;
            ST_XCLAMP: begin
               if (xs < 0) begin
                  x_ff <= '0;
               end else if (xs > $signed({2'b0, ONE_Q16})) begin
                  x_ff <= ONE_Q16;
               end else begin
                  x_ff <= xs[Q16_W-1:0];
               end
               state_ff <= ST_PMUL;
            end
            ST_PMUL: state_ff <= ST_QMUL;
            ST_QMUL: begin
               p_ff     <= (40'(a00_ff) <<< 16) + 40'(prod_ff);
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               neg_ff   <= diff_v < 0;
               m_ff     <= (diff_v < 0) ? 40'(-diff_v) : 40'(diff_v);
               state_ff <= ST_HIMUL;
            end
            ST_HIMUL: state_ff <= ST_LOMUL;
            ST_LOMUL: begin
               hi_ff    <= prod_ff;
               state_ff <= ST_FINAL;
            end
            ST_FINAL: begin
               two_segs_ff <= 1'b1;
               state_ff    <= ST_OUT0;
               if (f_v == lvl_v) begin
                  kind0_ff <= PAIR_BT;
                  kind1_ff <= PAIR_LR;
               end else if ((f_v > lvl_v && a11_ff > level_ff) ||
                            (f_v < lvl_v && a11_ff < level_ff)) begin
                  kind0_ff <= PAIR_LT;
                  kind1_ff <= PAIR_BR;
               end else begin
                  kind0_ff <= PAIR_LB;
                  kind1_ff <= PAIR_TR;
               end
            end
            ST_OUT0: begin
               if (rsp_tready) begin
                  state_ff <= two_segs_ff ? ST_OUT1 : ST_IDLE;
               end
            end
            ST_OUT1: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // endpoint coordinates in 10.12 fixed point
   function automatic logic [COORD_W-1:0] coord(input logic [31:0] base,
                                                input logic [Q16_W-1:0] frac);
      logic [31:0] sum;
      sum = (base << FRAC_W) + 32'(frac >> (Q16_FRAC - FRAC_W));
      return sum[COORD_W-1:0];
   endfunction

   logic [31:0]        col_m1, col_0, row_m1, row_0;
   logic [COORD_W-1:0] b_x, b_y, t_x, t_y, l_x, l_y, r_x, r_y;
   logic [COORD_W-1:0] sx, sy, ex, ey;
   pair_type           kind_sel;

   assign col_0  = 32'(cur_col_ff);
   assign col_m1 = col_0 - 32'd1;
   assign row_0  = 32'(cur_row_ff);
   assign row_m1 = row_0 - 32'd1;

   assign b_x = coord(col_m1, frac_b_ff);
   assign b_y = coord(row_m1, '0);
   assign t_x = coord(col_m1, frac_t_ff);
   assign t_y = coord(row_0, '0);
   assign l_x = coord(col_m1, '0);
   assign l_y = coord(row_m1, frac_l_ff);
   assign r_x = coord(col_0, '0);
   assign r_y = coord(row_m1, frac_r_ff);

   assign kind_sel = (state_ff == ST_OUT1) ? kind1_ff : kind0_ff;

   // segment endpoints by pairing
   always_comb begin
      case (kind_sel)
         PAIR_BR: begin sx = b_x; sy = b_y; ex = r_x; ey = r_y; end
         PAIR_LB: begin sx = l_x; sy = l_y; ex = b_x; ey = b_y; end
         PAIR_LR: begin sx = l_x; sy = l_y; ex = r_x; ey = r_y; end
         PAIR_TR: begin sx = t_x; sy = t_y; ex = r_x; ey = r_y; end
         PAIR_BT: begin sx = b_x; sy = b_y; ex = t_x; ey = t_y; end
         default: begin sx = l_x; sy = l_y; ex = t_x; ey = t_y; end
      endcase
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_OUT0 || state_ff == ST_OUT1;
   assign rsp_tdata  = {ey, ex, sy, sx};
   assign rsp_tlast  = (state_ff == ST_OUT1) || !two_segs_ff;

   // no sample is taken while a segment waits
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("sample accepted while a segment is pending");

   // the first of two segments is followed by the second
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second segment of a saddle cell lost");

   // the divider is started only when a state that waits for it follows
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> state_ff == ST_EDGE_WAIT || state_ff == ST_DIV_WAIT)
      else $error("divider started without a wait state");

endmodule

FILE: bench/msq_segment_checker.sv
`timescale 1ns / 1ps

// watches the three ports, predicts the segments of every accepted sample and
// compares them with the segments that leave the block
module msq_segment_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [msq_pkg::SAMPLE_W-1:0]    req_tdata,   // sample
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [msq_pkg::RSP_W-1:0]       rsp_tdata,   // start_x, start_y, end_x, end_y
   input  logic                            rsp_tlast,   // last_segment
   input  logic                            csr_write,
   input  logic [msq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [msq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              failures,
   output int                              pending
);
   import msq_pkg::*;

   localparam longint ONE = 65536;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               last_segment;
   } segment_type;

   typedef enum int {PAIR_BT_LR, PAIR_LT_BR, PAIR_LB_TR} pairing_type;

   segment_type expected_segments[$];

   // shadow of the block state and configuration
   longint level;
   int     columns_reg;
   int     rows_reg;
   longint line_store[ROW_MAX];
   longint left_value;
   longint upper_left_value;
   int     column_pos;
   int     row_pos;

   function automatic longint crossing(longint a, longint b);
      longint n;
      longint d;
      n = level - a;
      d = b - a;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (d == 0 || n <= 0) return 0;
      if (n >= d) return ONE;
      return (n << 16) / d;
   endfunction

   // product with a q16 fraction, truncated toward zero
   function automatic longint scale_q16(longint a, longint y);
      longint m;
      longint r;
      m = (a < 0) ? -a : a;
      r = (m >>> 16) * y + (((m & 64'hFFFF) * y) >>> 16);
      return (a < 0) ? -r : r;
   endfunction

   function automatic longint clip_q16(longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
   endfunction

   function automatic logic [COORD_W-1:0] to_coord(int base, longint f);
      longint v;
      v = (longint'(base) << FRAC_W) + (f >>> (Q16_FRAC - FRAC_W));
      return v[COORD_W-1:0];
   endfunction

   // saddle resolution by the surface value at the joining lines' crossing
   function automatic pairing_type saddle_pairing(longint a00, longint a01, longint a10,
                                                  longint a11, longint fb, longint ft,
                                                  longint fl, longint fr);
      longint dx;
      longint dy;
      longint den;
      longint num;
      longint yq;
      longint xq;
      longint p;
      longint q;
      longint f;
      longint v;
      dx  = ft - fb;
      dy  = fr - fl;
      den = ONE * ONE - dx * dy;
      num = fb * dy + fl * ONE;
      if (den <= 0) return PAIR_LB_TR;
      yq = clip_q16((num * ONE) / den);
      xq = clip_q16(fb + scale_q16(dx, yq));
      p  = a00 * ONE + (a01 - a00) * xq;
      q  = a10 * ONE + (a11 - a10) * xq;
      f  = p + scale_q16(q - p, yq);
      v  = level * ONE;
      if (f == v) return PAIR_BT_LR;
      if ((f > v && a11 > level) || (f < v && a11 < level)) return PAIR_LT_BR;
      return PAIR_LB_TR;
   endfunction

   function automatic void add_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                       logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                                       logic last);
      segment_type s;
      s.start_x = x0;
      s.start_y = y0;
      s.end_x = x1;
      s.end_y = y1;
      s.last_segment = last;
      expected_segments = {expected_segments, s};
   endfunction

   function automatic void close_cell(int c, int r, longint a00, longint a01,
                                      longint a10, longint a11);
      int code;
      longint fb, ft, fl, fr;
      logic [COORD_W-1:0] bx, by, tx, ty, lx, ly, rx, ry;
      pairing_type pairing;
      code = 0;
      if (a01 >= level) code += 1;
      if (a00 >= level) code += 2;
      if (a11 >= level) code += 4;
      if (a10 >= level) code += 8;
      fb = crossing(a00, a01);
      ft = crossing(a10, a11);
      fl = crossing(a00, a10);
      fr = crossing(a01, a11);
      bx = to_coord(c - 1, fb);
      by = to_coord(r - 1, 0);
      tx = to_coord(c - 1, ft);
      ty = to_coord(r, 0);
      lx = to_coord(c - 1, 0);
      ly = to_coord(r - 1, fl);
      rx = to_coord(c, 0);
      ry = to_coord(r - 1, fr);
      case (code)
         1, 14: add_segment(bx, by, rx, ry, 1'b1);
         2, 13: add_segment(lx, ly, bx, by, 1'b1);
         3, 12: add_segment(lx, ly, rx, ry, 1'b1);
         4, 11: add_segment(tx, ty, rx, ry, 1'b1);
         5, 10: add_segment(bx, by, tx, ty, 1'b1);
         7, 8:  add_segment(lx, ly, tx, ty, 1'b1);
         6, 9: begin
            pairing = saddle_pairing(a00, a01, a10, a11, fb, ft, fl, fr);
            case (pairing)
               PAIR_BT_LR: begin
                  add_segment(bx, by, tx, ty, 1'b0);
                  add_segment(lx, ly, rx, ry, 1'b1);
               end
               PAIR_LT_BR: begin
                  add_segment(lx, ly, tx, ty, 1'b0);
                  add_segment(bx, by, rx, ry, 1'b1);
               end
               default: begin
                  add_segment(lx, ly, bx, by, 1'b0);
                  add_segment(tx, ty, rx, ry, 1'b1);
               end
            endcase
         end
         default: ;
      endcase
   endfunction

   // one sample through the raster counters
   function automatic void take_sample(longint s);
      int cols;
      int rows;
      longint up;
      cols = (columns_reg < 2) ? 2 : (columns_reg > ROW_MAX) ? ROW_MAX : columns_reg;
      rows = (rows_reg < 2) ? 2 : (rows_reg > ROW_MAX) ? ROW_MAX : rows_reg;
      if (column_pos >= cols) begin
         column_pos = 0;
         row_pos++;
      end
      if (row_pos >= rows) row_pos = 0;
      up = line_store[column_pos];
      if (row_pos > 0 && column_pos > 0)
         close_cell(column_pos, row_pos, upper_left_value, up, left_value, s);
      line_store[column_pos] = s;
      upper_left_value = up;
      left_value = s;
      column_pos++;
      if (column_pos >= cols) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= rows) row_pos = 0;
      end
   endfunction

   initial begin
      failures = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      segment_type got;
      segment_type want;
      if (reset) begin
         level = 0;
         columns_reg = 2;
         rows_reg = 2;
         foreach (line_store[i]) line_store[i] = 0;
         left_value = 0;
         upper_left_value = 0;
         column_pos = 0;
         row_pos = 0;
         expected_segments.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_CONTOUR_LEVEL: level = longint'($signed(csr_wdata));
               CSR_GRID_COLUMNS:  columns_reg = int'(csr_wdata[GRID_REG_W-1:0]);
               CSR_GRID_ROWS:     rows_reg = int'(csr_wdata[GRID_REG_W-1:0]);
               default: ;
            endcase
         end
         // sample transaction
         if (req_tvalid && req_tready) take_sample(longint'($signed(req_tdata)));
         // segment transaction
         if (rsp_tvalid && rsp_tready) begin
            got.start_x = rsp_tdata[COORD_W-1:0];
            got.start_y = rsp_tdata[2*COORD_W-1:COORD_W];
            got.end_x = rsp_tdata[3*COORD_W-1:2*COORD_W];
            got.end_y = rsp_tdata[4*COORD_W-1:3*COORD_W];
            got.last_segment = rsp_tlast;
            if (expected_segments.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected segment %h %h %h %h last %b", got.start_x,
                           got.start_y, got.end_x, got.end_y, got.last_segment);
            end else begin
               want = expected_segments.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                              want.start_x, want.start_y, want.end_x, want.end_y,
                              want.last_segment, got.start_x, got.start_y, got.end_x,
                              got.end_y, got.last_segment);
               end
            end
         end
      end
      pending = expected_segments.size();
   end

endmodule

FILE: bench/tb_marching_squares_segmenter_core.sv
`timescale 1ns / 1ps

module tb_marching_squares_segmenter_core;
   import msq_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CONTOUR_LEVEL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     failures;
   int                     pending;

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int current_level = 0;
   int samples_sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   marching_squares_segmenter_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   msq_segment_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      static int hold_seen = 0;
      static int hold_left = 0;
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic set_idling(idle_mode_type mode);
      send_gap_pct = (mode == IDLE_SEND) ? 85 : (mode == IDLE_BOTH) ? 18 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 85 : (mode == IDLE_BOTH) ? 18 : 0;
   endtask

   // one sample transaction, with random gaps ahead of it
   task automatic send_sample(logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      samples_sent++;
   endtask

   // wait until every segment is in, then let a cell with no segment finish
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, int value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_wdata = value[CSR_DATA_W-1:0];
      if (index == CSR_CONTOUR_LEVEL) current_level = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_grid(int level, int cols, int rows);
      drain();
      write_reg(CSR_CONTOUR_LEVEL, level);
      write_reg(CSR_GRID_COLUMNS, cols);
      write_reg(CSR_GRID_ROWS, rows);
   endtask

   task automatic send_cell(int a00, int a01, int a10, int a11);
      send_sample(a00[SAMPLE_W-1:0]);
      send_sample(a01[SAMPLE_W-1:0]);
      send_sample(a10[SAMPLE_W-1:0]);
      send_sample(a11[SAMPLE_W-1:0]);
   endtask

   // whole frame; unless full_range is set, near the level most of the time so saddles turn up often
   task automatic send_frame(int cols, int rows, bit full_range);
      int spread;
      int v;
      spread = $urandom_range(1, 40);
      for (int i = 0; i < cols * rows; i++) begin
         if (full_range || $urandom_range(9) == 0)
            v = $urandom_range(16'hFFFF);
         else
            v = current_level + $urandom_range(2 * spread) - spread;
         send_sample(v[SAMPLE_W-1:0]);
      end
   endtask

   initial begin
      int level;
      int cols;
      int rows;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed cells on a 2x2 grid
      set_idling(IDLE_NONE);
      set_grid(0, 2, 2);
      send_cell(-32768, 32767, 32767, -32768);
      send_cell(10, -10, -10, 10);
      send_cell(-5, -5, -5, -5);
      send_cell(5, 5, 5, 5);
      send_cell(0, -7, -3, 0);
      set_grid(32767, 2, 2);
      send_cell(32767, 0, 0, 32767);
      // geometry below the minimum is taken as 2x2
      set_grid(-32768, 0, 1);
      send_cell(-32768, 32767, -1, 0);

      // wide and tall frames
      set_grid(0, 96, 2);
      send_frame(96, 2, 1'b1);
      set_grid(-3, 2, 96);
      send_frame(2, 96, 1'b0);

      // random frames under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         set_idling(idle_mode_type'(phase));
         samples_sent = 0;
         if (phase == 0) hold_requests++;
         while (samples_sent < 60) begin
            case ($urandom_range(7))
               0: level = 32767;
               1: level = -32768;
               default: level = $urandom_range(16'hFFFF) - 32768;
            endcase
            cols = ($urandom_range(9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 8);
            rows = $urandom_range(2, 6);
            set_grid(level, cols, rows);
            send_frame(cols, rows, $urandom_range(3) == 0);
         end
      end

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
